### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the flash page placer.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define IFPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define IFPP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### hw/rtl/ifpp_pkg.sv
// Constants and shared types of the interleaved flash page placer.
// No dependencies; used by the channel interfaces and all RTL modules.
package ifpp_pkg;

   localparam int NUM_CHIPS        = 8;
   localparam int PAGES_PER_CHIP   = 32768;
   localparam int PAGES_PER_SECTOR = 16;
   localparam int PAGE_BYTES       = 256;
   localparam int MAX_RUN          = 64;

   localparam int CHIP_W     = $clog2(NUM_CHIPS);
   localparam int IDX_W      = $clog2(PAGES_PER_CHIP + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int SECTOR_W   = $clog2(PAGES_PER_SECTOR);
   localparam int ADDR_W     = 23;
   localparam int CNT_W      = 7;
   localparam int TOTAL_W    = 32;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Output of the shared page step unit
   typedef struct packed {
      logic [ADDR_W-1:0] page_address;
      logic              erase_request;
      logic [ADDR_W-1:0] erase_address;
      logic              wrapped;
      logic [IDX_W-1:0]  next_index;
   } step_result_type;

endpackage

### hw/rtl/ifpp_req_if.sv
// Request channel of the flash page placer: valid/ready plus request payload.
// Depends on ifpp_pkg.
interface ifpp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [ifpp_pkg::CNT_W-1:0]  page_count;

   modport source (output valid, output req_type, output page_count, input ready);
   modport sink   (input valid, input req_type, input page_count, output ready);
endinterface

### hw/rtl/ifpp_rsp_if.sv
// Result channel of the flash page placer: valid/ready plus one page placement.
// Depends on ifpp_pkg.
interface ifpp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ifpp_pkg::CHIP_W-1:0]  chip_select;
   logic [ifpp_pkg::ADDR_W-1:0]  page_address;
   logic                         erase_request;
   logic [ifpp_pkg::ADDR_W-1:0]  erase_address;
   logic                         ring_wrapped;
   logic [ifpp_pkg::TOTAL_W-1:0] pages_written;
   logic                         last_of_run;

   modport source (output valid, output chip_select, output page_address,
                   output erase_request, output erase_address, output ring_wrapped,
                   output pages_written, output last_of_run, input ready);
   modport sink   (input valid, input chip_select, input page_address,
                   input erase_request, input erase_address, input ring_wrapped,
                   input pages_written, input last_of_run, output ready);
endinterface

### hw/rtl/ifpp_step.sv
// Shared page step unit: wraps a ring index, advances it and checks for a
// sector boundary. Depends on ifpp_pkg.
module ifpp_step (
   input  logic [ifpp_pkg::IDX_W-1:0] idx_cur,
   input  logic                       is_write,
   output ifpp_pkg::step_result_type  res
);

   function automatic logic [ifpp_pkg::ADDR_W-1:0] page_to_addr(
      input logic [ifpp_pkg::IDX_W-1:0] idx);
      logic [ifpp_pkg::IDX_W+ifpp_pkg::PAGE_SHIFT-1:0] b;
      b = (ifpp_pkg::IDX_W + ifpp_pkg::PAGE_SHIFT)'(idx) << ifpp_pkg::PAGE_SHIFT;
      return b[ifpp_pkg::ADDR_W-1:0];
   endfunction

   logic                       wrapped;
   logic [ifpp_pkg::IDX_W-1:0] idx_use;
   logic [ifpp_pkg::IDX_W-1:0] idx_nxt;
   logic                       at_sector;
   logic                       at_end;

   assign wrapped   = idx_cur >= ifpp_pkg::IDX_W'(ifpp_pkg::PAGES_PER_CHIP);
   assign idx_use   = wrapped ? '0 : idx_cur;
   assign idx_nxt   = idx_use + ifpp_pkg::IDX_W'(1);
   assign at_sector = idx_nxt[ifpp_pkg::SECTOR_W-1:0] == '0;
   assign at_end    = idx_nxt >= ifpp_pkg::IDX_W'(ifpp_pkg::PAGES_PER_CHIP);

   always_comb begin
      res.page_address  = page_to_addr(idx_use);
      res.erase_request = is_write && at_sector;
      // erase due at the chip end goes to sector 0
      res.erase_address = (is_write && at_sector && !at_end) ? page_to_addr(idx_nxt) : '0;
      res.wrapped       = wrapped;
      res.next_index    = idx_nxt;
   end

endmodule

### hw/rtl/interleaved_flash_page_placer.sv
// Result beats are registered: an accepted request loads the run state, and each page step
// is captured in the result registers. A write places one page; a read run of N pages places
// N, one page per cycle through the single page step unit while the output is not stalled;
// a zero-page read places none. New requests wait until the run ends. Reset is synchronous,
// active high, and clears all chip pointers, page index tables, the page count and wrap flag.
`include "assert_macros.svh"

module interleaved_flash_page_placer (
   input  logic            clock,
   input  logic            reset,
   ifpp_req_if.sink        req_bus,
   ifpp_rsp_if.source      rsp_bus
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                           state_ff, state_in;
   logic                           is_read_ff, is_read_in;
   logic [ifpp_pkg::CNT_W-1:0]     remain_ff, remain_in;
   logic [ifpp_pkg::CHIP_W-1:0]    wr_chip_ff, wr_chip_in;
   logic [ifpp_pkg::CHIP_W-1:0]    rd_chip_ff, rd_chip_in;
   logic [ifpp_pkg::IDX_W-1:0]     wr_idx_ff [ifpp_pkg::NUM_CHIPS];
   logic [ifpp_pkg::IDX_W-1:0]     wr_idx_in [ifpp_pkg::NUM_CHIPS];
   logic [ifpp_pkg::IDX_W-1:0]     rd_idx_ff [ifpp_pkg::NUM_CHIPS];
   logic [ifpp_pkg::IDX_W-1:0]     rd_idx_in [ifpp_pkg::NUM_CHIPS];
   logic [ifpp_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic                           wrap_ff, wrap_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [ifpp_pkg::CHIP_W-1:0]    chip_out_ff, chip_out_in;
   logic [ifpp_pkg::ADDR_W-1:0]    page_addr_ff, page_addr_in;
   logic                           erase_req_ff, erase_req_in;
   logic [ifpp_pkg::ADDR_W-1:0]    erase_addr_ff, erase_addr_in;
   logic                           ring_ff, ring_in;
   logic [ifpp_pkg::TOTAL_W-1:0]   written_ff, written_in;
   logic                           last_ff, last_in;

   logic [ifpp_pkg::CHIP_W-1:0]    cur_chip;
   logic [ifpp_pkg::CHIP_W-1:0]    nxt_chip;
   logic [ifpp_pkg::IDX_W-1:0]     cur_idx;
   logic [ifpp_pkg::CNT_W-1:0]     cnt_sat;
   logic                           accept;
   logic                           step_go;
   ifpp_pkg::step_result_type      step_res;

   assign cur_chip = is_read_ff ? rd_chip_ff : wr_chip_ff;
   assign cur_idx  = is_read_ff ? rd_idx_ff[cur_chip] : wr_idx_ff[cur_chip];
   assign nxt_chip = (cur_chip == ifpp_pkg::CHIP_W'(ifpp_pkg::NUM_CHIPS - 1)) ?
                     '0 : cur_chip + ifpp_pkg::CHIP_W'(1);
   assign cnt_sat  = (req_bus.page_count > ifpp_pkg::CNT_W'(ifpp_pkg::MAX_RUN)) ?
                     ifpp_pkg::CNT_W'(ifpp_pkg::MAX_RUN) : req_bus.page_count;

   assign req_bus.ready = state_ff == ST_IDLE;
   assign accept        = req_bus.valid && state_ff == ST_IDLE;
   assign step_go       = state_ff == ST_RUN && (!rsp_valid_ff || rsp_bus.ready);

   ifpp_step u_step (
      .idx_cur  (cur_idx),
      .is_write (!is_read_ff),
      .res      (step_res)
   );

   always_comb begin
      state_in      = state_ff;
      is_read_in    = is_read_ff;
      remain_in     = remain_ff;
      wr_chip_in    = wr_chip_ff;
      rd_chip_in    = rd_chip_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      total_in      = total_ff;
      wrap_in       = wrap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      chip_out_in   = chip_out_ff;
      page_addr_in  = page_addr_ff;
      erase_req_in  = erase_req_ff;
      erase_addr_in = erase_addr_ff;
      ring_in       = ring_ff;
      written_in    = written_ff;
      last_in       = last_ff;

      if (accept) begin
         if (req_bus.req_type == ifpp_pkg::REQ_WRITE) begin
            is_read_in = 1'b0;
            remain_in  = ifpp_pkg::CNT_W'(1);
            state_in   = ST_RUN;
         end else if (req_bus.req_type == ifpp_pkg::REQ_READ && cnt_sat == '0) begin
            // empty run still realigns the write pointer
            wr_chip_in = rd_chip_ff;
         end else begin
            is_read_in = 1'b1;
            remain_in  = cnt_sat;
            state_in   = ST_RUN;
         end
      end

      if (step_go) begin
         rsp_valid_in = 1'b1;
         chip_out_in  = cur_chip;
         page_addr_in = step_res.page_address;
         remain_in    = remain_ff - ifpp_pkg::CNT_W'(1);
         if (remain_ff == ifpp_pkg::CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
         if (!is_read_ff) begin
            wr_idx_in[cur_chip] = step_res.next_index;
            wr_chip_in          = nxt_chip;
            total_in            = total_ff + ifpp_pkg::TOTAL_W'(1);
            wrap_in             = wrap_ff | step_res.wrapped;
            erase_req_in        = step_res.erase_request;
            erase_addr_in       = step_res.erase_address;
            ring_in             = wrap_ff | step_res.wrapped;
            written_in          = total_ff + ifpp_pkg::TOTAL_W'(1);
            last_in             = 1'b1;
         end else begin
            rd_idx_in[cur_chip] = step_res.next_index;
            rd_chip_in          = nxt_chip;
            erase_req_in        = 1'b0;
            erase_addr_in       = '0;
            ring_in             = wrap_ff;
            written_in          = total_ff;
            last_in             = remain_ff == ifpp_pkg::CNT_W'(1);
            if (remain_ff == ifpp_pkg::CNT_W'(1)) begin
               wr_chip_in = nxt_chip;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_read_ff   <= 1'b0;
         remain_ff    <= '0;
         wr_chip_ff   <= '0;
         rd_chip_ff   <= '0;
         total_ff     <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ifpp_pkg::NUM_CHIPS; i++) begin
            wr_idx_ff[i] <= '0;
            rd_idx_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         is_read_ff   <= is_read_in;
         remain_ff    <= remain_in;
         wr_chip_ff   <= wr_chip_in;
         rd_chip_ff   <= rd_chip_in;
         total_ff     <= total_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   // result beat payload, no reset needed
   always_ff @(posedge clock) begin
      chip_out_ff   <= chip_out_in;
      page_addr_ff  <= page_addr_in;
      erase_req_ff  <= erase_req_in;
      erase_addr_ff <= erase_addr_in;
      ring_ff       <= ring_in;
      written_ff    <= written_in;
      last_ff       <= last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.chip_select   = chip_out_ff;
   assign rsp_bus.page_address  = page_addr_ff;
   assign rsp_bus.erase_request = erase_req_ff;
   assign rsp_bus.erase_address = erase_addr_ff;
   assign rsp_bus.ring_wrapped  = ring_ff;
   assign rsp_bus.pages_written = written_ff;
   assign rsp_bus.last_of_run   = last_ff;

   `IFPP_NEVER(a_run_has_work, state_ff == ST_RUN && remain_ff == '0, "run state with no pages left")
   `IFPP_ASSERT(a_wrap_sticky, $fell(wrap_ff) |-> $past(reset), "wrap flag cleared outside reset")
   `IFPP_ASSERT(a_count_step, total_ff != $past(total_ff) |-> total_ff == $past(total_ff) + 32'd1 || $past(reset), "page count moved by more than one")
   `IFPP_ASSERT(a_read_no_erase, step_go && is_read_ff |=> !erase_req_ff, "erase requested on a read beat")

endmodule
